FILE: sv/dttq_pkg.sv
// ----------------------------------------------------------------------------
// dttq_pkg
// Shared sizes, request codes and the control/status bundles of the delta
// timer task queue.
// ----------------------------------------------------------------------------
package dttq_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TICK_BITS = 16;
	localparam int ID_BITS   = 4;

	localparam int REQ_W  = 2;
	localparam int USED_W = 5;
	localparam int IDX_W  = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);

	localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POLL = 2'd2;

	typedef struct packed {
		logic load_req;
		logic tick_dec;
		logic reject;
		logic pop;
		logic scan_init;
		logic scan_step;
		logic insert;
		logic load_out;
	} dttq_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             empty;
		logic             full;
		logic             head_zero;
		logic             head_per_nz;
		logic             scan_adv;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} dttq_stat_t;

endpackage

FILE: sv/dttq_req_if.sv
// ----------------------------------------------------------------------------
// dttq_req_if
// Request channel: tick, add task or dispatch poll.
// ----------------------------------------------------------------------------
interface dttq_req_if import dttq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [ID_BITS-1:0]   task_id;
	logic [TICK_BITS-1:0] start_delay;
	logic [TICK_BITS-1:0] repeat_period;

	modport source (
		output valid, req_type, task_id, start_delay, repeat_period,
		input  ready
	);
	modport sink (
		input  valid, req_type, task_id, start_delay, repeat_period,
		output ready
	);
endinterface

FILE: sv/dttq_rsp_if.sv
// ----------------------------------------------------------------------------
// dttq_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface dttq_rsp_if import dttq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               due_valid;
	logic [ID_BITS-1:0] due_task;
	logic               add_rejected;
	logic [USED_W-1:0]  entries_used;

	modport source (
		output valid, due_valid, due_task, add_rejected, entries_used,
		input  ready
	);
	modport sink (
		input  valid, due_valid, due_task, add_rejected, entries_used,
		output ready
	);
endinterface

FILE: sv/dttq_ctrl.sv
// ----------------------------------------------------------------------------
// dttq_ctrl
// Sequencer: accepts a request, decodes it, steps the insertion scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module dttq_ctrl import dttq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  dttq_stat_t stat,
	output dttq_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_FIN;
				unique case (stat.req)
					REQ_TICK: begin
						cmd.tick_dec = !stat.empty && !stat.head_zero;
					end
					REQ_ADD: begin
						if (stat.full) begin
							cmd.reject = 1'b1;
						end else begin
							cmd.scan_init = 1'b1;
							state_nxt     = ST_SCAN;
						end
					end
					REQ_POLL: begin
						if (!stat.empty && stat.head_zero) begin
							cmd.pop = 1'b1;
							// periodic task goes back in at its period
							if (stat.head_per_nz) begin
								cmd.scan_init = 1'b1;
								state_nxt     = ST_SCAN;
							end
						end
					end
					default: begin
						state_nxt = ST_FIN;
					end
				endcase
			end
			ST_SCAN: begin
				if (stat.scan_adv) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.insert = 1'b1;
					state_nxt  = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: sv/dttq_dp.sv
// ----------------------------------------------------------------------------
// dttq_dp
// Datapath: the delta list in a row of shiftable entries, the insertion
// scan accumulator, the entry count and the output register.
// ----------------------------------------------------------------------------
module dttq_dp import dttq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dttq_cmd_t            cmd,
	output dttq_stat_t           stat,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [ID_BITS-1:0]   task_id,
	input  logic [TICK_BITS-1:0] start_delay,
	input  logic [TICK_BITS-1:0] repeat_period,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic                 due_valid,
	output logic [ID_BITS-1:0]   due_task,
	output logic                 add_rejected,
	output logic [USED_W-1:0]    entries_used
);

	logic [TICK_BITS-1:0] delta_q  [MAX_TASKS];
	logic [TICK_BITS-1:0] period_q [MAX_TASKS];
	logic [ID_BITS-1:0]   task_q   [MAX_TASKS];
	logic [CNT_W-1:0]     count_q;

	logic [REQ_W-1:0]     req_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TICK_BITS-1:0] delay_q;
	logic [TICK_BITS-1:0] per_q;
	logic [IDX_W-1:0]     pos_q;
	logic [TICK_BITS-1:0] cum_q;
	logic                 due_q;
	logic [ID_BITS-1:0]   due_task_q;
	logic                 rej_q;

	logic                 out_valid_q;
	logic                 out_due_q;
	logic [ID_BITS-1:0]   out_task_q;
	logic                 out_rej_q;
	logic [USED_W-1:0]    out_used_q;

	logic [TICK_BITS:0]   scan_sum;
	logic [TICK_BITS-1:0] ins_delta;

	assign scan_sum  = {1'b0, cum_q} + {1'b0, delta_q[pos_q]};
	assign ins_delta = delay_q - cum_q;

	always_comb begin
		stat.req         = req_q;
		stat.empty       = (count_q == '0);
		stat.full        = (count_q == CNT_W'(MAX_TASKS));
		stat.head_zero   = (delta_q[0] == '0);
		stat.head_per_nz = (period_q[0] != '0);
		stat.scan_adv    = (CNT_W'(pos_q) < count_q) && (scan_sum <= {1'b0, delay_q});
		stat.out_free    = !out_valid_q || rsp_ready;
		stat.count       = count_q;
	end

	// entry row: count the head down on tick, shift down on pop, open a slot at pos on insert
	always_ff @(posedge clk) begin
		if (cmd.tick_dec) begin
			delta_q[0] <= delta_q[0] - 1'b1;
		end
		for (int k = 0; k < MAX_TASKS; k++) begin
			if (cmd.pop && k < MAX_TASKS - 1) begin
				delta_q[k]  <= delta_q[k+1];
				period_q[k] <= period_q[k+1];
				task_q[k]   <= task_q[k+1];
			end
			if (cmd.insert) begin
				if (IDX_W'(k) == pos_q) begin
					delta_q[k]  <= ins_delta;
					period_q[k] <= per_q;
					task_q[k]   <= id_q;
				end else if (k > 0 && IDX_W'(k) > pos_q) begin
					period_q[k] <= period_q[k-1];
					task_q[k]   <= task_q[k-1];
					if (IDX_W'(k - 1) == pos_q) begin
						delta_q[k] <= delta_q[k-1] - ins_delta;
					end else begin
						delta_q[k] <= delta_q[k-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q      <= req_type;
			id_q       <= task_id;
			delay_q    <= start_delay;
			per_q      <= repeat_period;
			due_q      <= 1'b0;
			due_task_q <= '0;
			rej_q      <= 1'b0;
		end
		if (cmd.reject) begin
			rej_q <= 1'b1;
		end
		if (cmd.pop) begin
			due_q      <= 1'b1;
			due_task_q <= task_q[0];
			id_q       <= task_q[0];
			delay_q    <= period_q[0];
			per_q      <= period_q[0];
		end
		if (cmd.scan_init) begin
			pos_q <= '0;
			cum_q <= '0;
		end else if (cmd.scan_step) begin
			pos_q <= pos_q + 1'b1;
			cum_q <= scan_sum[TICK_BITS-1:0];
		end
		if (cmd.load_out) begin
			out_due_q  <= due_q;
			out_task_q <= due_task_q;
			out_rej_q  <= rej_q;
			out_used_q <= USED_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.insert) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = out_valid_q;
	assign due_valid    = out_due_q;
	assign due_task     = out_task_q;
	assign add_rejected = out_rej_q;
	assign entries_used = out_used_q;

endmodule

FILE: sv/delta_timer_task_queue.sv
// ----------------------------------------------------------------------------
// delta_timer_task_queue
// Time-ordered task queue holding each entry's delay relative to the one
// before it; tick, add and dispatch-poll requests, one response each.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  req     | in  | req_type, task_id, start_delay, repeat_period
//  rsp     | out | due_valid, due_task, add_rejected, entries_used
//
//  Tick, rejected add, idle poll: IDLE accepts, EXEC decodes, FIN loads the response.
//  Add or periodic re-add: SCAN between EXEC and FIN, passing p entries
//  (up to MAX_TASKS - 1); the scan reads one delta per cycle.
//  One request in flight; the next is taken once the previous one has
//  reached the output register, even while that result is still stalled.
//  Reset clears the entry count and the response valid; entry contents
//  are left as they are.
// ----------------------------------------------------------------------------
module delta_timer_task_queue import dttq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	dttq_req_if.sink   req,
	dttq_rsp_if.source rsp
);

	dttq_cmd_t  cmd;
	dttq_stat_t stat;

	dttq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dttq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req.req_type),
		.task_id       (req.task_id),
		.start_delay   (req.start_delay),
		.repeat_period (req.repeat_period),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.due_valid     (rsp.due_valid),
		.due_task      (rsp.due_task),
		.add_rejected  (rsp.add_rejected),
		.entries_used  (rsp.entries_used)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(MAX_TASKS))
		else $error("entry count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in flight");

	a_reject_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.add_rejected |-> rsp.entries_used == USED_W'(MAX_TASKS))
		else $error("add rejected with room left");

	a_due_excl_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.due_valid && rsp.add_rejected))
		else $error("release and reject in one response");

	a_pop_not_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !cmd.insert && !stat.empty)
		else $error("pop on empty queue or with insert");

endmodule

FILE: tb/dttq_schedule_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dttq_schedule_checker
// Watches both channels of the delta timer task queue. Keeps its own copy of
// the time-ordered task list, works out the response of every accepted
// request, and compares each accepted response with the oldest open one.
// ----------------------------------------------------------------------------
module dttq_schedule_checker import dttq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dttq_req_if  req_mon,
	dttq_rsp_if  rsp_mon,
	output int   fail_count,
	output int   pending,
	output int   queued,
	output int   released_count,
	output int   refused_count
);

	typedef struct packed {
		logic               due_valid;
		logic [ID_BITS-1:0] due_task;
		logic               add_rejected;
		logic [USED_W-1:0]  entries_used;
	} sched_outcome_t;

	// time-ordered list, slot 0 is the head; deltas are relative to the slot before
	logic [TICK_BITS-1:0] delta_q  [MAX_TASKS];
	logic [TICK_BITS-1:0] period_q [MAX_TASKS];
	logic [ID_BITS-1:0]   task_q   [MAX_TASKS];
	int                   task_total;

	sched_outcome_t open_q[$];
	sched_outcome_t want;
	int             fails;
	int             released;
	int             refused;

	function automatic bit place_task(logic [ID_BITS-1:0] id, logic [TICK_BITS-1:0] delay,
		logic [TICK_BITS-1:0] period);
		int unsigned          acc;
		int                   pos;
		logic [TICK_BITS-1:0] rel;
		if (task_total >= MAX_TASKS)
			return 1'b0;
		acc = 0;
		pos = 0;
		// pass every entry due at or before the requested delay
		while (pos < task_total && acc + 32'(delta_q[pos]) <= 32'(delay)) begin
			acc += 32'(delta_q[pos]);
			pos++;
		end
		rel = delay - acc[TICK_BITS-1:0];
		if (pos < task_total)
			delta_q[pos] -= rel;
		for (int k = task_total; k > pos; k--) begin
			delta_q[k]  = delta_q[k-1];
			period_q[k] = period_q[k-1];
			task_q[k]   = task_q[k-1];
		end
		delta_q[pos]  = rel;
		period_q[pos] = period;
		task_q[pos]   = id;
		task_total++;
		return 1'b1;
	endfunction

	function automatic sched_outcome_t predict_outcome(logic [REQ_W-1:0] kind,
		logic [ID_BITS-1:0] id, logic [TICK_BITS-1:0] delay, logic [TICK_BITS-1:0] period);
		sched_outcome_t       res;
		logic [ID_BITS-1:0]   head_id;
		logic [TICK_BITS-1:0] head_per;
		res = '0;
		case (kind)
			REQ_TICK: begin
				if (task_total > 0 && delta_q[0] != 0)
					delta_q[0]--;
			end
			REQ_ADD: begin
				res.add_rejected = !place_task(id, delay, period);
			end
			REQ_POLL: begin
				if (task_total > 0 && delta_q[0] == 0) begin
					head_id  = task_q[0];
					head_per = period_q[0];
					for (int k = 1; k < task_total; k++) begin
						delta_q[k-1]  = delta_q[k];
						period_q[k-1] = period_q[k];
						task_q[k-1]   = task_q[k];
					end
					task_total--;
					res.due_valid = 1'b1;
					res.due_task  = head_id;
					// re-arm a periodic task; a slot was just freed
					if (head_per != 0)
						void'(place_task(head_id, head_per, head_per));
				end
			end
			default: ;
		endcase
		res.entries_used = task_total[USED_W-1:0];
		return res;
	endfunction

	function automatic int field_mismatch(string name, logic [7:0] exp_val, logic [7:0] act_val);
		if (exp_val === act_val)
			return 0;
		$display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_total = 0;
			open_q.delete();
			fails    = 0;
			released = 0;
			refused  = 0;
			fail_count     <= 0;
			pending        <= 0;
			queued         <= 0;
			released_count <= 0;
			refused_count  <= 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (open_q.size() == 0) begin
					$display("%0t  response with no open request: %s %0b %s %0d %s %0b %s %0d",
						$time, "due_valid", rsp_mon.due_valid, "due_task",
						rsp_mon.due_task, "add_rejected", rsp_mon.add_rejected,
						"entries_used", rsp_mon.entries_used);
					fails++;
				end else begin
					want = open_q.pop_front();
					fails += field_mismatch("due_valid", 8'(want.due_valid),
						8'(rsp_mon.due_valid));
					fails += field_mismatch("due_task", 8'(want.due_task),
						8'(rsp_mon.due_task));
					fails += field_mismatch("add_rejected", 8'(want.add_rejected),
						8'(rsp_mon.add_rejected));
					fails += field_mismatch("entries_used", 8'(want.entries_used),
						8'(rsp_mon.entries_used));
				end
			end
			if (req_mon.valid && req_mon.ready) begin
				want = predict_outcome(req_mon.req_type, req_mon.task_id, req_mon.start_delay,
					req_mon.repeat_period);
				if (want.due_valid)
					released++;
				if (want.add_rejected)
					refused++;
				open_q.push_back(want);
			end
			fail_count     <= fails;
			pending        <= open_q.size();
			queued         <= task_total;
			released_count <= released;
			refused_count  <= refused;
		end
	end

endmodule

FILE: tb/delta_timer_task_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_timer_task_queue_tb
// Drives tick, add and dispatch-poll requests into the delta timer task queue
// with random gaps on both channels: a directed opening, then a long random
// stream; the schedule checker predicts and compares every response.
// ----------------------------------------------------------------------------
module delta_timer_task_queue_tb;
	import dttq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 700;
	localparam int STALL_MAX     = 17;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_LIMIT    = 2000;
	localparam int ID_MAX        = (1 << ID_BITS) - 1;
	localparam int TICK_MAX      = (1 << TICK_BITS) - 1;

	logic clk;
	logic arst_n;

	dttq_req_if req_ch();
	dttq_rsp_if rsp_ch();

	int fail_count;
	int pending;
	int queued;
	int released_count;
	int refused_count;
	int sent_count  = 0;
	int idle_cycles = 0;
	bit send_burst  = 1'b0;
	bit take_burst  = 1'b0;

	delta_timer_task_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dttq_schedule_checker sched_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_mon        (req_ch),
		.rsp_mon        (rsp_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.queued         (queued),
		.released_count (released_count),
		.refused_count  (refused_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_request(logic [REQ_W-1:0] kind, logic [ID_BITS-1:0] id,
		logic [TICK_BITS-1:0] delay, logic [TICK_BITS-1:0] period);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.req_type      <= kind;
		req_ch.task_id       <= id;
		req_ch.start_delay   <= delay;
		req_ch.repeat_period <= period;
		req_ch.valid         <= 1'b1;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		sent_count++;
	endtask

	// hold the request channel until every open response is back
	task automatic wait_all_answered();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// response side: random stalls with bursts of steady acceptance
	initial begin
		int stall;
		int taken;
		taken = 0;
		forever begin
			if (taken % 40 == 0)
				take_burst = ($urandom_range(0, 3) == 0);
			stall = take_burst ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t  no request or response accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int                   directed_count;
		int                   pick;
		bit                   wide;
		logic [REQ_W-1:0]     kind;
		logic [ID_BITS-1:0]   id;
		logic [TICK_BITS-1:0] delay;
		logic [TICK_BITS-1:0] period;

		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_TICK;
		req_ch.task_id       = '0;
		req_ch.start_delay   = '0;
		req_ch.repeat_period = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, then the unused code with every field bit set
		send_request(REQ_TICK, 0, 0, 0);
		send_request(REQ_POLL, 0, 0, 0);
		send_request(REQ_UNUSED, ID_BITS'(ID_MAX), TICK_BITS'(TICK_MAX),
			TICK_BITS'(TICK_MAX));
		// insert ahead of a lone tail, then an equal delay lands after it
		send_request(REQ_ADD, 0, 5, 0);
		send_request(REQ_ADD, ID_BITS'(ID_MAX), 2, 0);
		send_request(REQ_ADD, 3, 2, 0);
		send_request(REQ_POLL, 0, 0, 0);
		// count the head down to zero and once more
		send_request(REQ_TICK, 0, 0, 0);
		send_request(REQ_TICK, 0, 0, 0);
		send_request(REQ_TICK, 0, 0, 0);
		send_request(REQ_POLL, 0, 0, 0);
		send_request(REQ_POLL, 0, 0, 0);
		// periodic task: dispatch and re-arm behind the remaining entry
		send_request(REQ_ADD, 7, 0, 3);
		send_request(REQ_POLL, 0, 0, 0);
		send_request(REQ_ADD, 9, TICK_BITS'(TICK_MAX), TICK_BITS'(TICK_MAX));
		// fill the queue, then one add too many
		for (int n = 0; n < MAX_TASKS - 3; n++)
			send_request(REQ_ADD, ID_BITS'(n), TICK_BITS'($urandom_range(0, 3)), 0);
		send_request(REQ_ADD, 5, 16'hAAAA, 16'h5555);
		directed_count = sent_count;
		wait_all_answered();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				wait_all_answered();
			pick = $urandom_range(0, 99);
			id   = ID_BITS'($urandom_range(0, ID_MAX));
			// wide values only where they are refused or near the end,
			// since an entry far out never drains
			wide = (queued >= MAX_TASKS) ||
				(i >= RANDOM_ITEMS - 80 && $urandom_range(0, 2) == 0);
			if (pick < 3)
				kind = REQ_UNUSED;
			else if (pick < 40)
				kind = REQ_TICK;
			else if (pick < 72)
				kind = REQ_ADD;
			else
				kind = REQ_POLL;
			if (kind != REQ_ADD || wide) begin
				delay  = TICK_BITS'($urandom_range(0, TICK_MAX));
				period = TICK_BITS'(($urandom_range(0, 1) == 0) ? 0 :
					$urandom_range(0, TICK_MAX));
			end else begin
				delay  = TICK_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) :
					$urandom_range(0, 12));
				period = TICK_BITS'(($urandom_range(0, 19) == 0) ? $urandom_range(1, 10) : 0);
			end
			send_request(kind, id, delay, period);
		end

		wait_all_answered();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d directed, %0d random); polls released %0d tasks,",
			sent_count, directed_count, sent_count - directed_count, released_count);
		$display("%0d adds were refused on a full queue; %0d tasks queued at the end.",
			refused_count, queued);
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d field mismatches, %0d responses never arrived", fail_count, pending);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
